>>> design/dsd_pkg.sv
package dsd_pkg;

	// Calendar span covered from the base year on
	localparam int YEAR_SPAN = 256;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 12;
	localparam int BACK_W  = 17;

	localparam int BASE_YEAR    = 1900;
	localparam int YEAR_LAST    = BASE_YEAR + YEAR_SPAN - 1;
	localparam int CENTURY      = 100;
	localparam int QUAD_CENTURY = 400;
	localparam int DAYS_LEAP    = 366;
	localparam int DAYS_COMMON  = 365;
	localparam int FEB_LEAP     = 29;
	localparam int FEB_COMMON   = 28;
	localparam int MONTHS       = 12;

	// Largest serial: every year of the span, a full extra year of months, a day
	localparam int SERIAL_MAX   = YEAR_SPAN * DAYS_LEAP + DAYS_LEAP + 31;
	localparam int SERIAL_RAW_W = $clog2(SERIAL_MAX + 1);
	localparam int SERIAL_W     = (SERIAL_RAW_W > BACK_W) ? SERIAL_RAW_W : BACK_W;

	localparam int YLEN_W = $clog2(DAYS_LEAP + 1);
	localparam int MLEN_W = 5;
	localparam int M100_W = $clog2(CENTURY);
	localparam int M400_W = $clog2(QUAD_CENTURY);

	localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(MONTHS);

	localparam logic [M100_W-1:0] BASE_MOD100 = M100_W'(BASE_YEAR % CENTURY);
	localparam logic [M400_W-1:0] BASE_MOD400 = M400_W'(BASE_YEAR % QUAD_CENTURY);
	localparam logic [M100_W-1:0] MOD100_LAST = M100_W'(CENTURY - 1);
	localparam logic [M400_W-1:0] MOD400_LAST = M400_W'(QUAD_CENTURY - 1);

	localparam logic [MLEN_W-1:0] MONTH_DAYS [MONTHS] = '{
		MLEN_W'(31), MLEN_W'(FEB_COMMON), MLEN_W'(31), MLEN_W'(30),
		MLEN_W'(31), MLEN_W'(30), MLEN_W'(31), MLEN_W'(31),
		MLEN_W'(30), MLEN_W'(31), MLEN_W'(30), MLEN_W'(31)
	};

	typedef logic [SERIAL_W-1:0] serial_t;
	typedef logic [YEAR_W-1:0]   year_t;
	typedef logic [MONTH_W-1:0]  month_t;
	typedef logic [DAY_W-1:0]    day_t;
	typedef logic [BACK_W-1:0]   back_t;

	typedef struct packed {
		logic clear;
		logic sub;
		logic load;
	} alu_ctrl_t;

	typedef struct packed {
		logic restart;
		logic year_inc;
		logic month_inc;
	} cursor_ctrl_t;

	// Days in month m; zero for month codes outside January..December
	function automatic logic [MLEN_W-1:0] month_len(input month_t m, input logic leap);
		logic [MLEN_W-1:0] len;
		len = '0;
		if (m >= JANUARY && m <= DECEMBER) begin
			if (m == FEBRUARY && leap)
				len = MLEN_W'(FEB_LEAP);
			else
				len = MONTH_DAYS[m - JANUARY];
		end
		return len;
	endfunction

endpackage

>>> design/dsd_in_if.sv
interface dsd_in_if;
	logic                           valid;
	logic                           ready;
	logic [dsd_pkg::DAY_W-1:0]      in_day;
	logic [dsd_pkg::MONTH_W-1:0]    in_month;
	logic [dsd_pkg::YEAR_W-1:0]     in_year;
	logic [dsd_pkg::BACK_W-1:0]     days_back;

	modport source(output valid, output in_day, output in_month, output in_year,
		output days_back, input ready);
	modport sink(input valid, input in_day, input in_month, input in_year,
		input days_back, output ready);
endinterface

>>> design/dsd_out_if.sv
interface dsd_out_if;
	logic                           valid;
	logic                           ready;
	logic [dsd_pkg::DAY_W-1:0]      out_day;
	logic [dsd_pkg::MONTH_W-1:0]    out_month;
	logic [dsd_pkg::YEAR_W-1:0]     out_year;
	logic                           underflow;

	modport source(output valid, output out_day, output out_month, output out_year,
		output underflow, input ready);
	modport sink(input valid, input out_day, input out_month, input out_year,
		input underflow, output ready);
endinterface

>>> design/date_subtract_days_core.sv
// Gregorian date minus a day count. A beat on query carries a date (day, month,
// year) and days_back; one beat on answer returns the date that many days
// earlier. Years are saturated into 1900..1900+YEAR_SPAN-1 first; the day is
// not checked against the month, so it rolls over (day 0 is the last day of the
// month before), month 0 adds no days and months 13..15 count as the full year.
// A result before 1900-01-01 comes back as 1900-01-01 with underflow set.
// One item at a time: query.ready is high only while the block is idle. After
// acceptance the single add/subtract accumulator, with the calendar cursor,
// walks years one per cycle and then months one per cycle, first up to the start
// date and then, with the cursor restarted at 1900-01, over the remainder left
// once days_back is taken off; the block then goes back to idle before the next
// query is taken. The answer is held in an output register, so a stalled answer
// side delays only the end of the next item.
module date_subtract_days_core (
	input  logic        clk,
	input  logic        arst_n,
	dsd_in_if.sink      query,
	dsd_out_if.source   answer
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FWD_YEAR,
		S_FWD_MONTH,
		S_FWD_DAY,
		S_CHECK,
		S_REV_YEAR,
		S_REV_MONTH
	} state_t;

	state_t state_q;

	// latched item
	dsd_pkg::day_t   day_q;
	dsd_pkg::month_t month_q;
	dsd_pkg::year_t  year_q;
	dsd_pkg::back_t  back_q;

	// answer register
	logic            out_valid_q;
	dsd_pkg::day_t   out_day_q;
	dsd_pkg::month_t out_month_q;
	dsd_pkg::year_t  out_year_q;
	logic            underflow_q;

	dsd_pkg::alu_ctrl_t    alu_ctrl;
	dsd_pkg::cursor_ctrl_t cur_ctrl;
	dsd_pkg::serial_t      opnd;
	dsd_pkg::serial_t      acc;
	logic                  gt;

	dsd_pkg::year_t                    cur_year;
	dsd_pkg::month_t                   cur_month;
	logic [dsd_pkg::YLEN_W-1:0]        year_len;
	logic [dsd_pkg::MLEN_W-1:0]        month_len;

	dsd_pkg::year_t  year_in;
	logic            out_free;
	logic            out_load;

	// saturate incoming year into the covered span
	always_comb begin
		if (query.in_year < dsd_pkg::year_t'(dsd_pkg::BASE_YEAR))
			year_in = dsd_pkg::year_t'(dsd_pkg::BASE_YEAR);
		else if (query.in_year > dsd_pkg::year_t'(dsd_pkg::YEAR_LAST))
			year_in = dsd_pkg::year_t'(dsd_pkg::YEAR_LAST);
		else
			year_in = query.in_year;
	end

	assign out_free = !out_valid_q || answer.ready;

	// answer register takes a result: clamp in check, or final month found
	assign out_load = out_free && !gt &&
	                  ((state_q == S_CHECK) || (state_q == S_REV_MONTH));

	dsd_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (alu_ctrl),
		.opnd   (opnd),
		.acc    (acc),
		.gt     (gt)
	);

	dsd_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (cur_ctrl),
		.year      (cur_year),
		.month     (cur_month),
		.year_len  (year_len),
		.month_len (month_len)
	);

	// Step decode. Forward phase builds the serial (years, months, day),
	// check subtracts days_back, reverse phase peels whole years then months
	// off the remainder starting from 1900-01.
	always_comb begin
		alu_ctrl = '0;
		cur_ctrl = '0;
		opnd     = '0;
		case (state_q)
			S_IDLE: begin
				if (query.valid) begin
					alu_ctrl.clear   = 1'b1;
					cur_ctrl.restart = 1'b1;
				end
			end
			S_FWD_YEAR: begin
				opnd = dsd_pkg::SERIAL_W'(year_len);
				if (cur_year < year_q) begin
					alu_ctrl.load     = 1'b1;
					cur_ctrl.year_inc = 1'b1;
				end
			end
			S_FWD_MONTH: begin
				opnd = dsd_pkg::SERIAL_W'(month_len);
				if (cur_month < month_q) begin
					alu_ctrl.load      = 1'b1;
					cur_ctrl.month_inc = 1'b1;
				end
			end
			S_FWD_DAY: begin
				opnd          = dsd_pkg::SERIAL_W'(day_q);
				alu_ctrl.load = 1'b1;
			end
			S_CHECK: begin
				opnd         = dsd_pkg::SERIAL_W'(back_q);
				alu_ctrl.sub = 1'b1;
				if (gt) begin
					alu_ctrl.load    = 1'b1;
					cur_ctrl.restart = 1'b1;
				end
			end
			S_REV_YEAR: begin
				opnd         = dsd_pkg::SERIAL_W'(year_len);
				alu_ctrl.sub = 1'b1;
				if (gt) begin
					alu_ctrl.load     = 1'b1;
					cur_ctrl.year_inc = 1'b1;
				end
			end
			S_REV_MONTH: begin
				opnd         = dsd_pkg::SERIAL_W'(month_len);
				alu_ctrl.sub = 1'b1;
				if (gt) begin
					alu_ctrl.load      = 1'b1;
					cur_ctrl.month_inc = 1'b1;
				end
			end
			default: begin
				alu_ctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			day_q       <= '0;
			month_q     <= '0;
			year_q      <= '0;
			back_q      <= '0;
			out_day_q   <= '0;
			out_month_q <= '0;
			out_year_q  <= '0;
			underflow_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (answer.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (query.valid) begin
						day_q   <= query.in_day;
						month_q <= query.in_month;
						year_q  <= year_in;
						back_q  <= query.days_back;
						state_q <= S_FWD_YEAR;
					end
				end
				S_FWD_YEAR: begin
					if (!(cur_year < year_q))
						state_q <= S_FWD_MONTH;
				end
				S_FWD_MONTH: begin
					if (!(cur_month < month_q))
						state_q <= S_FWD_DAY;
				end
				S_FWD_DAY: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (gt) begin
						state_q <= S_REV_YEAR;
					end else if (out_free) begin
						// before 1900-01-01: clamp
						out_day_q   <= dsd_pkg::day_t'(1);
						out_month_q <= dsd_pkg::JANUARY;
						out_year_q  <= dsd_pkg::year_t'(dsd_pkg::BASE_YEAR);
						underflow_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_REV_YEAR: begin
					if (!gt)
						state_q <= S_REV_MONTH;
				end
				S_REV_MONTH: begin
					// remainder fits the month once gt drops
					if (!gt && out_free) begin
						out_day_q   <= acc[dsd_pkg::DAY_W-1:0];
						out_month_q <= cur_month;
						out_year_q  <= cur_year;
						underflow_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign query.ready      = (state_q == S_IDLE);
	assign answer.valid     = out_valid_q;
	assign answer.out_day   = out_day_q;
	assign answer.out_month = out_month_q;
	assign answer.out_year  = out_year_q;
	assign answer.underflow = underflow_q;

endmodule

>>> design/dsd_alu.sv
// Accumulator with one shared add/subtract; gt is valid while sub is set
module dsd_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  dsd_pkg::alu_ctrl_t ctrl,
	input  dsd_pkg::serial_t   opnd,
	output dsd_pkg::serial_t   acc,
	output logic               gt
);

	dsd_pkg::serial_t acc_q;
	dsd_pkg::serial_t opx;
	dsd_pkg::serial_t res;
	logic             carry;

	always_comb begin
		opx          = ctrl.sub ? ~opnd : opnd;
		{carry, res} = {1'b0, acc_q} + {1'b0, opx} + (dsd_pkg::SERIAL_W + 1)'(ctrl.sub);
		// no borrow and nonzero difference
		gt           = carry && (res != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.load) begin
			acc_q <= res;
		end
	end

	assign acc = acc_q;

endmodule

>>> design/dsd_cursor.sv
// Calendar position walker; leap status from the year's low bits and mod-100/mod-400 counters
module dsd_cursor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dsd_pkg::cursor_ctrl_t             ctrl,
	output dsd_pkg::year_t                    year,
	output dsd_pkg::month_t                   month,
	output logic [dsd_pkg::YLEN_W-1:0]        year_len,
	output logic [dsd_pkg::MLEN_W-1:0]        month_len
);

	dsd_pkg::year_t                 year_q;
	dsd_pkg::month_t                month_q;
	logic [dsd_pkg::M100_W-1:0]     m100_q;
	logic [dsd_pkg::M400_W-1:0]     m400_q;
	logic                           leap;

	assign leap = (m400_q == '0) || ((year_q[1:0] == 2'b00) && (m100_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= dsd_pkg::year_t'(dsd_pkg::BASE_YEAR);
			month_q <= dsd_pkg::JANUARY;
			m100_q  <= dsd_pkg::BASE_MOD100;
			m400_q  <= dsd_pkg::BASE_MOD400;
		end else if (ctrl.restart) begin
			year_q  <= dsd_pkg::year_t'(dsd_pkg::BASE_YEAR);
			month_q <= dsd_pkg::JANUARY;
			m100_q  <= dsd_pkg::BASE_MOD100;
			m400_q  <= dsd_pkg::BASE_MOD400;
		end else begin
			if (ctrl.year_inc) begin
				year_q <= year_q + dsd_pkg::year_t'(1);
				m100_q <= (m100_q == dsd_pkg::MOD100_LAST) ? '0
				                                           : m100_q + dsd_pkg::M100_W'(1);
				m400_q <= (m400_q == dsd_pkg::MOD400_LAST) ? '0
				                                           : m400_q + dsd_pkg::M400_W'(1);
			end
			if (ctrl.month_inc)
				month_q <= month_q + dsd_pkg::month_t'(1);
		end
	end

	assign year      = year_q;
	assign month     = month_q;
	assign year_len  = leap ? dsd_pkg::YLEN_W'(dsd_pkg::DAYS_LEAP)
	                        : dsd_pkg::YLEN_W'(dsd_pkg::DAYS_COMMON);
	assign month_len = dsd_pkg::month_len(month_q, leap);

endmodule
